// ===== rtl/lekrb_pkg.sv =====
// Package for the line-editing keyboard ring buffer.
// Holds sizes, codes, payload and RAM request types, and pointer helpers.
// No dependencies.
package lekrb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 8;
    localparam int COUNT_W      = 6;

    // Command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_LINE = 1'b1;

    // Special keys
    localparam logic [BYTE_W-1:0] KEY_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'd8;

    // Result kinds
    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_NO_LINE = 2'd3;

    // A line read with max_len at or above this is rejected
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(BUFFER_DEPTH);

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] key;
        logic [LEN_W-1:0]  max_len;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BYTE_W-1:0]  data;
        logic               echo;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               last;
    } rsp_item_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_RD_REQ,
        S_BYTE,
        S_SCAN,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_fwd(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(BUFFER_DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// ===== rtl/lekrb_ifc.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on lekrb_pkg for the payload types.
interface lekrb_req_if;
    import lekrb_pkg::*;
    logic      valid;
    logic      ready;
    req_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lekrb_rsp_if;
    import lekrb_pkg::*;
    logic      valid;
    logic      ready;
    rsp_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lekrb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lekrb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/lekrb_ostage.sv =====
// Output register stage for the result channel.
// Depends on lekrb_pkg and lekrb_rsp_if.
module lekrb_ostage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lekrb_pkg::rsp_item_t item,
    output logic                 free,
    lekrb_rsp_if.source          rsp
);
    import lekrb_pkg::*;

    logic      valid_reg;
    rsp_item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign free        = !valid_reg || rsp.ready;
    assign rsp.valid   = valid_reg;
    assign rsp.payload = item_reg;
endmodule

// ===== rtl/lekrb_ctrl.sv =====
// Sequencer: keystroke update, line byte readout and newline scan.
// Depends on lekrb_pkg and lekrb_req_if; drives the ring RAM and output stage.
module lekrb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    lekrb_req_if.sink            req,
    output lekrb_pkg::ram_req_t  ram_req,
    input  logic [lekrb_pkg::BYTE_W-1:0] ram_rdata,
    input  logic                 out_free,
    output logic                 out_load,
    output lekrb_pkg::rsp_item_t out_item
);
    import lekrb_pkg::*;

    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]   max_len_reg, max_len_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   nl_pos_reg, nl_pos_next;
    logic               nl_valid_reg, nl_valid_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]         status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            nl_pos_reg   <= '0;
            nl_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nl_pos_reg   <= nl_pos_next;
            nl_valid_reg <= nl_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        max_len_reg <= max_len_next;
        cnt_reg     <= cnt_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        max_len_next  = max_len_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nl_pos_next   = nl_pos_reg;
        nl_valid_next = nl_valid_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        ram_req       = '0;
        out_load      = 1'b0;
        out_item      = '0;
        req.ready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next     = req.payload.key;
                    max_len_next = req.payload.max_len;
                    cnt_next     = '0;
                    status_next  = ST_OK;
                    if (req.payload.cmd == CMD_KEY)
                    begin
                        state_next = S_KEY;
                    end
                    else if (req.payload.max_len >= LEN_LIMIT)
                    begin
                        status_next = ST_BAD_LEN;
                        state_next  = S_DONE;
                    end
                    else if (!nl_valid_reg)
                    begin
                        status_next = ST_NO_LINE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD_REQ;
                    end
                end
            end

            S_KEY:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_item.kind = KIND_KEY;
                    out_item.data = key_reg;
                    out_item.last = 1'b1;
                    state_next    = S_IDLE;
                    if (ptr_fwd(tail_reg) == head_reg)
                    begin
                        out_item.status = ST_FULL;
                    end
                    else
                    begin
                        // backspace is stored too, then undone by the tail step
                        ram_req.we    = 1'b1;
                        ram_req.waddr = tail_reg;
                        ram_req.wdata = key_reg;
                        if (key_reg == KEY_NEWLINE && !nl_valid_reg)
                        begin
                            nl_pos_next   = tail_reg;
                            nl_valid_next = 1'b1;
                        end
                        if (key_reg == KEY_BACKSPACE)
                        begin
                            if (tail_reg != head_reg)
                            begin
                                tail_next     = ptr_back(tail_reg);
                                out_item.echo = 1'b1;
                            end
                        end
                        else
                        begin
                            tail_next     = ptr_fwd(tail_reg);
                            out_item.echo = 1'b1;
                        end
                    end
                end
            end

            S_RD_REQ:
            begin
                if (LEN_W'(cnt_reg) == max_len_reg || head_reg == nl_pos_reg)
                begin
                    // drop the rest of the line and the newline
                    head_next   = ptr_fwd(nl_pos_reg);
                    nl_pos_next = ptr_fwd(nl_pos_reg);
                    state_next  = S_SCAN;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = head_reg;
                    state_next    = S_BYTE;
                end
            end

            S_BYTE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_item.kind = KIND_BYTE;
                    out_item.data = ram_rdata;
                    cnt_next      = cnt_reg + 1'b1;
                    head_next     = ptr_fwd(head_reg);
                    state_next    = S_RD_REQ;
                end
            end

            S_SCAN:
            begin
                if (nl_pos_reg == tail_reg)
                begin
                    nl_valid_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = nl_pos_reg;
                    state_next    = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (ram_rdata == KEY_NEWLINE)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    nl_pos_next = ptr_fwd(nl_pos_reg);
                    state_next  = S_SCAN;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_item.kind   = KIND_DONE;
                    out_item.status = status_reg;
                    out_item.count  = cnt_reg;
                    out_item.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/line_edit_key_ring_buffer.sv =====
// Top level of the line-editing keyboard ring buffer.
// Depends on lekrb_pkg, lekrb_ifc, lekrb_ram, lekrb_ostage and lekrb_ctrl.
//
//  channel | dir | payload                                   | transactions per item
//  --------+-----+-------------------------------------------+----------------------
//  req     | in  | cmd, key, max_len                         | 1
//  rsp     | out | kind, data, echo, status, count, last     | 1 .. max_len+1
//
// Steps: a keystroke is accepted, then its result is loaded. A line read is accepted,
// then each line byte is read from the RAM and loaded as a result; head then moves
// past the newline (skipped bytes are not read), the newline scan reads position
// by position until it finds a newline or hits the tail, and the done result is
// loaded. A rejected line read goes straight to the done result.
// The ring RAM has a single read port; one item is in work at a time.
// Reset clears the pointers and the pending-line flag; the RAM needs no clear.
// A stalled rsp holds its transaction in the output register; the sequencer
// waits for that register to free up before loading the next result.
module line_edit_key_ring_buffer (
    input  logic        clk,
    input  logic        rst_n,
    lekrb_req_if.sink   req,
    lekrb_rsp_if.source rsp
);
    import lekrb_pkg::*;

    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_free;
    logic              out_load;
    rsp_item_t         out_item;

    // ring store: written on keystrokes, read for line bytes and the scan
    lekrb_ram #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // sequencer holding head, tail and newline pointers
    lekrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_item  (out_item)
    );

    // result register between the sequencer and the rsp channel
    lekrb_ostage u_ostage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .item  (out_item),
        .free  (out_free),
        .rsp   (rsp)
    );
endmodule

// ===== rtl/lekrb_chk.sv =====
// Port-level checker for the line-editing keyboard ring buffer, with its bind.
// Depends on lekrb_pkg and the top level line_edit_key_ring_buffer.
module lekrb_chk (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input lekrb_pkg::rsp_item_t rsp_item
);
    import lekrb_pkg::*;

    // a held result keeps its value until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("rsp transaction changed while stalled");

    // one item at a time: no back-to-back request transactions
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while an item is in work");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.kind == KIND_KEY || rsp_item.kind == KIND_BYTE ||
                      rsp_item.kind == KIND_DONE)
        else $error("unused result kind");

    // line bytes are never final and carry no status
    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.kind == KIND_BYTE |->
            !rsp_item.last && !rsp_item.echo && rsp_item.status == ST_OK &&
            rsp_item.count == '0)
        else $error("bad line byte fields");

    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.kind != KIND_BYTE |-> rsp_item.last &&
            (rsp_item.kind == KIND_KEY || rsp_item.data == '0))
        else $error("bad final result fields");
endmodule

bind line_edit_key_ring_buffer lekrb_chk u_lekrb_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.payload)
);
